// ----- hw/rtl/nearest_neighbor_downscaler_top_assert.svh -----
// Assertion macros used by the downscaler checker.
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define NND_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define NND_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/nnd_pkg.sv -----
// Shared constants and types of the nearest-neighbour downscaler.
`default_nettype none
package nnd_pkg;

    localparam int CFG_W             = 13;
    localparam int CFG_IDX_W         = 8;
    localparam int PIX_W             = 24;
    localparam int MAX_DIMENSION_DEF = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 8'd0,
        CFG_SOURCE_HEIGHT = 8'd1,
        CFG_TARGET_WIDTH  = 8'd2,
        CFG_TARGET_HEIGHT = 8'd3
    } t_cfg_idx;

    typedef logic [PIX_W-1:0] t_pixel;

endpackage
`default_nettype wire

// ----- hw/rtl/nearest_neighbor_downscaler_top.sv -----
// Nearest-neighbour downscaler: top level with position tracking and output staging.
// Takes one source pixel per clock while o_stall is low, in raster order, and passes on
// those that fall on the destination grid, with end-of-line and end-of-frame marks;
// dropped pixels give no item. Each accepted pixel is decided in the cycle it is taken,
// from running column and row accumulators (adds and compares only). An output
// register backed by a one-entry skid stage keeps the rate at one pixel per clock while
// i_stall is low; o_stall rises only while both hold an item. Any configuration write
// to a listed register restarts the frame; sizes of zero count as one, sizes above
// MAX_DIMENSION count as MAX_DIMENSION, and the target is limited to the source size.
`default_nettype none
module nearest_neighbor_downscaler_top #(
    parameter int MAX_DIMENSION = nnd_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [nnd_pkg::PIX_W-1:0]  i_pixel_in,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [nnd_pkg::PIX_W-1:0]       o_pixel_out,
    output logic                            o_end_of_line,
    output logic                            o_end_of_frame,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [nnd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [nnd_pkg::CFG_W-1:0]  i_cfg_data
);
    import nnd_pkg::*;

    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int PW = 2 * DW;

    function automatic logic [DW-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [DW-1:0] r;
        if (v == '0) begin
            r = DW'(1);
        end else if (int'(v) > MAX_DIMENSION) begin
            r = DW'(MAX_DIMENSION);
        end else begin
            r = DW'(v);
        end
        return r;
    endfunction

    logic [CFG_W-1:0] r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic [CFG_W-1:0] n_src_w, n_src_h, n_tgt_w, n_tgt_h;
    logic             cfg_hit;

    logic [DW-1:0] sw, sh, dw, dh, tw, th;

    logic [CW-1:0] r_sc, r_sr, n_sc, n_sr;
    logic [PW-1:0] r_csp, r_cnp, r_rsp, r_rnp;
    logic [PW-1:0] n_csp, n_cnp, n_rsp, n_rnp;
    logic          r_rik, n_rik;
    logic [DW-1:0] r_kc, r_kr, n_kc, n_kr;

    logic          accept;
    logic          col_kept, emit, eol, eof;
    logic [DW-1:0] kr_inc;
    logic [PW-1:0] rnp_inc, rsp_inc;

    logic          r_out_valid, n_out_valid;
    t_pixel        r_out_pix, n_out_pix;
    logic          r_out_eol, n_out_eol, r_out_eof, n_out_eof;
    logic          r_skid_valid, n_skid_valid;
    t_pixel        r_skid_pix, n_skid_pix;
    logic          r_skid_eol, n_skid_eol, r_skid_eof, n_skid_eof;
    logic          out_take;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skid_valid;
    assign accept      = i_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_stall;

    always_comb begin
        n_src_w = r_src_w;
        n_src_h = r_src_h;
        n_tgt_w = r_tgt_w;
        n_tgt_h = r_tgt_h;
        cfg_hit = 1'b0;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SOURCE_WIDTH: begin
                    n_src_w = i_cfg_data;
                    cfg_hit = 1'b1;
                end
                CFG_SOURCE_HEIGHT: begin
                    n_src_h = i_cfg_data;
                    cfg_hit = 1'b1;
                end
                CFG_TARGET_WIDTH: begin
                    n_tgt_w = i_cfg_data;
                    cfg_hit = 1'b1;
                end
                CFG_TARGET_HEIGHT: begin
                    n_tgt_h = i_cfg_data;
                    cfg_hit = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign sw = eff_size(r_src_w);
    assign sh = eff_size(r_src_h);
    assign tw = eff_size(r_tgt_w);
    assign th = eff_size(r_tgt_h);
    assign dw = (tw < sw) ? tw : sw;
    assign dh = (th < sh) ? th : sh;

    assign col_kept = (r_kc < dw) && (r_cnp < r_csp + PW'(dw));
    assign emit     = r_rik && col_kept;
    assign eol      = (r_kc + DW'(1)) == dw;
    assign eof      = eol && ((r_kr + DW'(1)) == dh);
    assign kr_inc   = r_kr + DW'(r_rik);
    assign rnp_inc  = r_rik ? (r_rnp + PW'(sh)) : r_rnp;
    assign rsp_inc  = r_rsp + PW'(dh);

    always_comb begin
        n_sc  = r_sc;
        n_sr  = r_sr;
        n_csp = r_csp;
        n_cnp = r_cnp;
        n_rsp = r_rsp;
        n_rnp = r_rnp;
        n_rik = r_rik;
        n_kc  = r_kc;
        n_kr  = r_kr;
        if (cfg_hit) begin
            n_sc  = '0;
            n_sr  = '0;
            n_csp = '0;
            n_cnp = '0;
            n_rsp = '0;
            n_rnp = '0;
            n_rik = 1'b1;
            n_kc  = '0;
            n_kr  = '0;
        end else if (accept) begin
            if ((DW'(r_sc) + DW'(1)) >= sw) begin
                n_sc  = '0;
                n_csp = '0;
                n_cnp = '0;
                n_kc  = '0;
                if ((DW'(r_sr) + DW'(1)) >= sh) begin
                    n_sr  = '0;
                    n_rsp = '0;
                    n_rnp = '0;
                    n_rik = 1'b1;
                    n_kr  = '0;
                end else begin
                    n_sr  = r_sr + CW'(1);
                    n_rsp = rsp_inc;
                    n_rnp = rnp_inc;
                    n_kr  = kr_inc;
                    n_rik = (kr_inc < dh) && (rnp_inc < rsp_inc + PW'(dh));
                end
            end else begin
                n_sc  = r_sc + CW'(1);
                n_csp = r_csp + PW'(dw);
                if (col_kept) begin
                    n_kc  = r_kc + DW'(1);
                    n_cnp = r_cnp + PW'(sw);
                end
            end
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_pix    = r_out_pix;
        n_out_eol    = r_out_eol;
        n_out_eof    = r_out_eof;
        n_skid_valid = r_skid_valid;
        n_skid_pix   = r_skid_pix;
        n_skid_eol   = r_skid_eol;
        n_skid_eof   = r_skid_eof;
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if (r_skid_valid && out_take) begin
            n_out_valid  = 1'b1;
            n_out_pix    = r_skid_pix;
            n_out_eol    = r_skid_eol;
            n_out_eof    = r_skid_eof;
            n_skid_valid = 1'b0;
        end else if (accept && emit && !cfg_hit) begin
            if (r_out_valid && !out_take) begin
                n_skid_valid = 1'b1;
                n_skid_pix   = i_pixel_in;
                n_skid_eol   = eol;
                n_skid_eof   = eof;
            end else begin
                n_out_valid = 1'b1;
                n_out_pix   = i_pixel_in;
                n_out_eol   = eol;
                n_out_eof   = eof;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w      <= CFG_W'(1);
            r_src_h      <= CFG_W'(1);
            r_tgt_w      <= CFG_W'(1);
            r_tgt_h      <= CFG_W'(1);
            r_sc         <= '0;
            r_sr         <= '0;
            r_csp        <= '0;
            r_cnp        <= '0;
            r_rsp        <= '0;
            r_rnp        <= '0;
            r_rik        <= 1'b1;
            r_kc         <= '0;
            r_kr         <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_src_w      <= n_src_w;
            r_src_h      <= n_src_h;
            r_tgt_w      <= n_tgt_w;
            r_tgt_h      <= n_tgt_h;
            r_sc         <= n_sc;
            r_sr         <= n_sr;
            r_csp        <= n_csp;
            r_cnp        <= n_cnp;
            r_rsp        <= n_rsp;
            r_rnp        <= n_rnp;
            r_rik        <= n_rik;
            r_kc         <= n_kc;
            r_kr         <= n_kr;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pix  <= n_out_pix;
        r_out_eol  <= n_out_eol;
        r_out_eof  <= n_out_eof;
        r_skid_pix <= n_skid_pix;
        r_skid_eol <= n_skid_eol;
        r_skid_eof <= n_skid_eof;
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_out    = r_out_pix;
    assign o_end_of_line  = r_out_eol;
    assign o_end_of_frame = r_out_eof;

endmodule
`default_nettype wire

// ----- hw/rtl/nnd_checker.sv -----
// Port-level checker for the downscaler, bound to the top level.
`default_nettype none
`include "nearest_neighbor_downscaler_top_assert.svh"
module nnd_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_stall,
    input wire logic                      o_valid,
    input wire logic                      i_stall,
    input wire logic [nnd_pkg::PIX_W-1:0] o_pixel_out,
    input wire logic                      o_end_of_line,
    input wire logic                      o_end_of_frame
);
    import nnd_pkg::*;

    `NND_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_pixel_out), "stalled output item changed")
    `NND_ASSERT_NOW(a_eof_eol, i_clk, i_rst_n, o_valid && o_end_of_frame, o_end_of_line, "end of frame without end of line")
    `NND_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, o_valid, "input stalled while output is empty")
    `NND_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $rose(i_rst_n), !o_valid && !o_stall, "item present after reset")

endmodule

bind nearest_neighbor_downscaler_top nnd_checker u_nnd_checker (.*);
`default_nettype wire

// ----- test/tb_nearest_neighbor_downscaler_top.sv -----
// Testbench of the nearest-neighbour downscaler: directed table, then random frames checked by a predictor.
module tb_nearest_neighbor_downscaler_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nnd_pkg::*;

    localparam int MAX_DIM        = MAX_DIMENSION_DEF;
    localparam int NUM_DIRECTED   = 31;
    localparam int RANDOM_ITEMS   = 450;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = CFG_IDX_W'(CFG_TARGET_HEIGHT + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_UNMAPPED   = '1;

    typedef struct packed {
        t_pixel pixel;
        logic   end_of_line;
        logic   end_of_frame;
    } t_scaled_px;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PIXEL,
        ROW_PIXEL_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       value;
        t_pixel                 px;
        logic                   kept;
        t_scaled_px             res;
    } t_directed_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_pixel               i_pixel_in = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_pixel               o_pixel_out;
    logic                 o_end_of_line;
    logic                 o_end_of_frame;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    logic [CFG_W-1:0] size_reg [4];
    int unsigned      src_col, src_row, col_pos, col_pick, row_pos, row_pick;
    int unsigned      cols_kept, rows_kept;
    bit               row_kept;

    t_scaled_px expected_pixels [$];
    int         mismatches = 0;
    int         results_seen = 0;
    int         quiet_cycles = 0;
    bit         calm = 1'b0;
    bit         cfg_open = 1'b0;

    nearest_neighbor_downscaler_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_in     (i_pixel_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_out    (o_pixel_out),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic void restart_frame();
        src_col   = 0;
        src_row   = 0;
        col_pos   = 0;
        col_pick  = 0;
        row_pos   = 0;
        row_pick  = 0;
        cols_kept = 0;
        rows_kept = 0;
        row_kept  = 1'b1;
    endfunction

    function automatic bit downscale_pixel(input t_pixel px, output t_scaled_px res);
        int unsigned sw, sh, dw, dh;
        bit          col_keep;
        bit          hit;
        sw = eff_dim(size_reg[CFG_SOURCE_WIDTH]);
        sh = eff_dim(size_reg[CFG_SOURCE_HEIGHT]);
        dw = eff_dim(size_reg[CFG_TARGET_WIDTH]);
        dh = eff_dim(size_reg[CFG_TARGET_HEIGHT]);
        if (dw > sw) dw = sw;
        if (dh > sh) dh = sh;
        col_keep = (cols_kept < dw) && (col_pick < col_pos + dw);
        hit = row_kept && col_keep;
        res.pixel        = px;
        res.end_of_line  = (cols_kept + 1 == dw);
        res.end_of_frame = res.end_of_line && (rows_kept + 1 == dh);
        if (col_keep) begin
            cols_kept++;
            col_pick += sw;
        end
        col_pos += dw;
        if (src_col + 1 >= sw) begin
            src_col   = 0;
            col_pos   = 0;
            col_pick  = 0;
            cols_kept = 0;
            if (row_kept) begin
                rows_kept++;
                row_pick += sh;
            end
            if (src_row + 1 >= sh) begin
                restart_frame();
            end else begin
                src_row++;
                row_pos += dh;
                row_kept = (rows_kept < dh) && (row_pick < row_pos + dh);
            end
        end else begin
            src_col++;
        end
        return hit;
    endfunction

    function automatic t_directed_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CFG_W-1:0] value);
        t_directed_row r;
        r = '0;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.value = value;
        return r;
    endfunction

    function automatic t_directed_row pix_row(input t_pixel px);
        t_directed_row r;
        r = '0;
        r.kind = ROW_PIXEL;
        r.px   = px;
        return r;
    endfunction

    function automatic t_directed_row known_row(input t_pixel px, input logic kept,
                                                input logic eol, input logic eof);
        t_directed_row r;
        r = '0;
        r.kind = ROW_PIXEL_KNOWN;
        r.px   = px;
        r.kept = kept;
        r.res  = '{px, eol, eof};
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] random_source_size(input bit wide);
        case ($urandom_range(24))
            0:       return '0;
            1:       return CFG_W'($urandom_range(8191, MAX_DIM + 1));
            2:       return CFG_W'(MAX_DIM);
            default: return CFG_W'($urandom_range(wide ? 12 : 7, 1));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_target_size(input logic [CFG_W-1:0] src);
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_W'($urandom);
            2:       return src + CFG_W'($urandom_range(3, 1));
            default: return CFG_W'($urandom_range(eff_dim(src), 1));
        endcase
    endfunction

    task automatic note_mismatch(input string what, input t_scaled_px want,
                                 input t_scaled_px seen);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s: expected %06h eol %0b eof %0b, got %06h eol %0b eof %0b", what,
                     want.pixel, want.end_of_line, want.end_of_frame,
                     seen.pixel, seen.end_of_line, seen.end_of_frame);
    endtask

    // hold the sender until every expected pixel is out and the block has settled
    task automatic drain();
        i_valid <= 1'b0;
        wait (expected_pixels.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        if (!cfg_open) drain();
        cfg_open = 1'b1;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= CFG_TARGET_HEIGHT) begin
            size_reg[idx] = value;
            restart_frame();
        end
    endtask

    task automatic send_pixel(input t_pixel px, input bit known, input bit known_kept,
                              input t_scaled_px known_res);
        t_scaled_px res;
        bit         kept;
        if (cfg_open) begin
            i_cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        while (!calm && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= px;
        do @(posedge i_clk); while (o_stall);
        kept = downscale_pixel(px, res);
        if (known) begin
            kept = known_kept;
            res  = known_res;
        end
        if (kept) expected_pixels.push_back(res);
    endtask

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 35);
    end

    always @(posedge i_clk) begin
        t_scaled_px seen;
        t_scaled_px want;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = '{o_pixel_out, o_end_of_line, o_end_of_frame};
            results_seen++;
            if (expected_pixels.size() == 0) begin
                note_mismatch("pixel with none expected", '0, seen);
            end else begin
                want = expected_pixels.pop_front();
                if (seen.pixel !== want.pixel || seen.end_of_line !== want.end_of_line ||
                    seen.end_of_frame !== want.end_of_frame)
                    note_mismatch("pixel differs", want, seen);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_directed_row steps [NUM_DIRECTED];
        int unsigned   frame_px;
        int unsigned   burst;
        int unsigned   random_items;
        int unsigned   phase;
        steps = '{
            known_row(24'hFFFFFF, 1'b1, 1'b1, 1'b1),
            known_row(24'h000000, 1'b1, 1'b1, 1'b1),
            cfg_row(CFG_SOURCE_WIDTH, '0),
            known_row(24'h123456, 1'b1, 1'b1, 1'b1),
            cfg_row(CFG_SOURCE_WIDTH, '1),
            known_row(24'h800001, 1'b1, 1'b1, 1'b1),
            pix_row(24'h7FFFFE),
            cfg_row(CFG_TARGET_WIDTH, '1),
            known_row(24'hAAAAAA, 1'b1, 1'b0, 1'b0),
            pix_row(24'h555555),
            cfg_row(CFG_SOURCE_WIDTH, 13'd3),
            pix_row(24'h0F0F0F),
            pix_row(24'hF0F0F0),
            pix_row(24'h3C3C3C),
            pix_row(24'hC3C3C3),
            cfg_row(CFG_TOP_UNMAPPED, '1),
            pix_row(24'h00FF00),
            pix_row(24'hFF00FF),
            cfg_row(CFG_SOURCE_HEIGHT, '1),
            cfg_row(CFG_TARGET_HEIGHT, '0),
            cfg_row(CFG_SOURCE_WIDTH, 13'd1),
            cfg_row(CFG_TARGET_WIDTH, '0),
            known_row(24'h0000FF, 1'b1, 1'b1, 1'b1),
            known_row(24'hFF0000, 1'b0, 1'b0, 1'b0),
            cfg_row(CFG_TARGET_HEIGHT, '1),
            known_row(24'h00FF00, 1'b1, 1'b1, 1'b0),
            pix_row(24'h010203),
            cfg_row(CFG_SOURCE_WIDTH, 13'd2),
            cfg_row(CFG_TARGET_WIDTH, 13'd1),
            known_row(24'h808080, 1'b1, 1'b1, 1'b0),
            known_row(24'h7F7F7F, 1'b0, 1'b0, 1'b0)
        };
        foreach (size_reg[r]) size_reg[r] = 13'd1;
        restart_frame();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[k]) begin
            case (steps[k].kind)
                ROW_CFG:   write_reg(steps[k].idx, steps[k].value);
                ROW_PIXEL: send_pixel(steps[k].px, 1'b0, 1'b0, '0);
                default:   send_pixel(steps[k].px, 1'b1, steps[k].kept, steps[k].res);
            endcase
        end

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            calm = (phase >= 4 && phase < 8);
            if (phase == 0 || $urandom_range(3) != 0)
                write_reg(CFG_SOURCE_WIDTH, random_source_size(1'b1));
            if (phase == 0 || $urandom_range(3) != 0)
                write_reg(CFG_SOURCE_HEIGHT, random_source_size(1'b0));
            if (phase == 0 || $urandom_range(3) != 0)
                write_reg(CFG_TARGET_WIDTH, random_target_size(size_reg[CFG_SOURCE_WIDTH]));
            if (phase == 0 || $urandom_range(3) != 0)
                write_reg(CFG_TARGET_HEIGHT, random_target_size(size_reg[CFG_SOURCE_HEIGHT]));
            if ($urandom_range(5) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_TOP_UNMAPPED, CFG_FIRST_UNMAPPED)),
                          CFG_W'($urandom));
            frame_px = eff_dim(size_reg[CFG_SOURCE_WIDTH]) *
                       eff_dim(size_reg[CFG_SOURCE_HEIGHT]);
            if (frame_px <= 96) begin
                burst = frame_px * $urandom_range(3, 1);
                if ($urandom_range(3) == 0) burst += $urandom_range(frame_px - 1, 0);
            end else begin
                burst = $urandom_range(40, 1);
            end
            if (burst > RANDOM_ITEMS - random_items) burst = RANDOM_ITEMS - random_items;
            for (int n = 0; n < burst; n++) begin
                if (phase == 2 && n == burst / 2) drain();
                send_pixel(t_pixel'($urandom), 1'b0, 1'b0, '0);
            end
            random_items += burst;
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/nnd_pkg.sv
hw/rtl/nearest_neighbor_downscaler_top.sv
hw/rtl/nnd_checker.sv
test/tb_nearest_neighbor_downscaler_top.sv
